// ===== hdl/edc_pkg.sv =====
// ============================================================================
// edc_pkg: shared types and constants for the edit distance core
// Sizes, request kinds, queue entry layout and the engine state encoding.
// ============================================================================
package edc_pkg;

    localparam int MAX_LEN     = 64;
    localparam int CHAR_BITS   = 16;
    localparam int CHAR_PORT_W = 16;
    localparam int KIND_W      = 2;
    localparam int DIST_W      = 7;
    localparam int DIST_MAX    = 127;

    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int SCORE_W = $clog2(MAX_LEN + 4);
    localparam int ROW_W   = 2;
    localparam int SADDR_W = $clog2(3 * MAX_LEN);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // request kinds on the input stream
    localparam logic [KIND_W-1:0] KIND_SRC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TGT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN = 2'd2;

    typedef enum logic [1:0] {
        OP_SRC,
        OP_TGT,
        OP_RUN
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [CHAR_BITS-1:0] ch;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } qhead_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_COL
    } bk_state_t;

    function automatic logic [DIST_W-1:0] sat_dist(input logic [SCORE_W-1:0] s);
        if (32'(s) > DIST_MAX)
        begin
            return DIST_W'(DIST_MAX);
        end
        return DIST_W'(s);
    endfunction

endpackage

// ===== hdl/edc_front.sv =====
// ============================================================================
// edc_front: request intake and command queue
// Decodes the request kind, drops unused kinds and queues commands.
// ============================================================================
module edc_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [edc_pkg::CHAR_PORT_W-1:0] s_tdata,
    input  logic [edc_pkg::KIND_W-1:0]      s_tuser,
    output edc_pkg::qhead_t                 head,
    input  logic                            pop
);
    import edc_pkg::*;

    cmd_t               q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    cmd_t               in_cmd;
    logic               keep;
    logic               push;
    logic               do_pop;

    // classify the request
    always_comb
    begin
        in_cmd.ch = s_tdata[CHAR_BITS-1:0];
        in_cmd.op = OP_SRC;
        keep      = 1'b0;
        case (s_tuser)
            KIND_SRC:
            begin
                in_cmd.op = OP_SRC;
                keep      = 1'b1;
            end
            KIND_TGT:
            begin
                in_cmd.op = OP_TGT;
                keep      = 1'b1;
            end
            KIND_RUN:
            begin
                in_cmd.op = OP_RUN;
                keep      = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready = (cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign push     = s_tvalid && s_tready && keep;
    assign do_pop   = pop && (cnt_reg != '0);

    assign head.valid = (cnt_reg != '0);
    assign head.cmd   = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push   ? Q_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? Q_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        case ({push, do_pop})
            2'b10:   cnt_next = Q_CNT_W'(cnt_reg + 1'b1);
            2'b01:   cnt_next = Q_CNT_W'(cnt_reg - 1'b1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== hdl/edc_back.sv =====
// ============================================================================
// edc_back: string stores and distance engine
// Appends characters and sweeps the score table one cell per cycle within a row.
// ============================================================================
module edc_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  edc_pkg::qhead_t            head,
    output logic                       pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata
);
    import edc_pkg::*;

    function automatic logic [SADDR_W-1:0] saddr(input logic [ROW_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
        return SADDR_W'(SADDR_W'(r) * SADDR_W'(MAX_LEN)) + SADDR_W'(c);
    endfunction

    // storage
    logic [CHAR_BITS-1:0] src_mem   [MAX_LEN];
    logic [CHAR_BITS-1:0] tgt_mem   [MAX_LEN];
    logic [SCORE_W-1:0]   score_mem [3 * MAX_LEN];

    logic [CHAR_BITS-1:0] src_rd_reg, tgt_rd_reg;
    logic [SCORE_W-1:0]   up_rd_reg, up2_rd_reg;

    bk_state_t            state_reg, state_next;
    logic [LEN_W-1:0]     src_len_reg, src_len_next;
    logic [LEN_W-1:0]     tgt_len_reg, tgt_len_next;
    logic                 drop_reg, drop_next;
    logic [LEN_W-1:0]     i_reg, i_next;
    logic [LEN_W-1:0]     j_reg, j_next;
    logic                 out_valid_reg, out_valid_next;

    logic [ROW_W-1:0]     cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]     up_row_reg, up_row_next;
    logic [ROW_W-1:0]     up2_row_reg, up2_row_next;
    logic [SCORE_W-1:0]   left_reg, left_next;
    logic [SCORE_W-1:0]   diag_reg, diag_next;
    logic [CHAR_BITS-1:0] src_prev_reg, src_prev_next;
    logic [CHAR_BITS-1:0] tc_prev_reg, tc_prev_next;
    logic [DIST_W-1:0]    out_dist_reg, out_dist_next;
    logic                 out_ovf_reg, out_ovf_next;

    logic                 src_we, tgt_we, sc_we, src_re, rd_issue;
    logic [LEN_W-1:0]     k_col;
    logic [IDX_W-1:0]     src_raddr, tgt_raddr;
    logic [SADDR_W-1:0]   up_addr, up2_addr, sc_waddr;

    logic [SCORE_W-1:0]   up_j, c_left, c_diag, c_up, trans, best;

    // one cell of the score table
    always_comb
    begin
        up_j   = (i_reg == LEN_W'(1)) ? SCORE_W'(j_reg) : up_rd_reg;
        c_left = SCORE_W'(left_reg + 1'b1);
        c_diag = SCORE_W'(diag_reg + SCORE_W'(src_rd_reg != tgt_rd_reg));
        c_up   = SCORE_W'(up_j + 1'b1);
        trans  = SCORE_W'(up2_rd_reg + 1'b1
                          + SCORE_W'(src_prev_reg != tgt_rd_reg)
                          + SCORE_W'(src_rd_reg != tc_prev_reg));
        best   = (c_left < c_diag) ? c_left : c_diag;
        if (c_up < best)
        begin
            best = c_up;
        end
        if ((i_reg > LEN_W'(2)) && (j_reg > LEN_W'(2)) && (trans < best))
        begin
            best = trans;
        end
    end

    // column whose reads are issued this cycle
    always_comb
    begin
        k_col     = (state_reg == ST_ROW) ? LEN_W'(1) : LEN_W'(j_reg + 1'b1);
        src_raddr = IDX_W'(i_reg - 1'b1);
        tgt_raddr = IDX_W'(k_col - 1'b1);
        up_addr   = saddr(up_row_reg, IDX_W'(k_col - 1'b1));
        up2_addr  = saddr(up2_row_reg,
                          (k_col > LEN_W'(2)) ? IDX_W'(k_col - LEN_W'(3)) : '0);
        sc_waddr  = saddr(cur_row_reg, IDX_W'(j_reg - 1'b1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid && (head.cmd.op == OP_RUN) && !out_valid_reg &&
                    (src_len_reg != '0) && (tgt_len_reg != '0))
                begin
                    state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                state_next = ST_COL;
            end
            ST_COL:
            begin
                if (j_reg == tgt_len_reg)
                begin
                    state_next = (i_reg == src_len_reg) ? ST_IDLE : ST_ROW;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        pop            = 1'b0;
        src_we         = 1'b0;
        tgt_we         = 1'b0;
        sc_we          = 1'b0;
        src_re         = 1'b0;
        rd_issue       = 1'b0;
        src_len_next   = src_len_reg;
        tgt_len_next   = tgt_len_reg;
        drop_next      = drop_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cur_row_next   = cur_row_reg;
        up_row_next    = up_row_reg;
        up2_row_next   = up2_row_reg;
        left_next      = left_reg;
        diag_next      = diag_reg;
        src_prev_next  = src_prev_reg;
        tc_prev_next   = tc_prev_reg;
        out_valid_next = out_valid_reg;
        out_dist_next  = out_dist_reg;
        out_ovf_next   = out_ovf_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    case (head.cmd.op)
                        OP_SRC:
                        begin
                            pop = 1'b1;
                            if (src_len_reg < LEN_W'(MAX_LEN))
                            begin
                                src_we       = 1'b1;
                                src_len_next = LEN_W'(src_len_reg + 1'b1);
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        OP_TGT:
                        begin
                            pop = 1'b1;
                            if (tgt_len_reg < LEN_W'(MAX_LEN))
                            begin
                                tgt_we       = 1'b1;
                                tgt_len_next = LEN_W'(tgt_len_reg + 1'b1);
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        OP_RUN:
                        begin
                            if (!out_valid_reg)
                            begin
                                pop = 1'b1;
                                if ((src_len_reg == '0) || (tgt_len_reg == '0))
                                begin
                                    // empty string: distance is the other length
                                    out_valid_next = 1'b1;
                                    out_dist_next  = sat_dist(SCORE_W'(
                                        (src_len_reg == '0) ? tgt_len_reg
                                                            : src_len_reg));
                                    out_ovf_next   = drop_reg;
                                    src_len_next   = '0;
                                    tgt_len_next   = '0;
                                    drop_next      = 1'b0;
                                end
                                else
                                begin
                                    i_next       = LEN_W'(1);
                                    cur_row_next = ROW_W'(1);
                                    up_row_next  = ROW_W'(0);
                                    up2_row_next = ROW_W'(2);
                                end
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_ROW:
            begin
                src_re        = 1'b1;
                rd_issue      = 1'b1;
                left_next     = SCORE_W'(i_reg);
                diag_next     = SCORE_W'(i_reg - 1'b1);
                src_prev_next = src_rd_reg;
                j_next        = LEN_W'(1);
            end
            ST_COL:
            begin
                sc_we        = 1'b1;
                left_next    = best;
                diag_next    = up_j;
                tc_prev_next = tgt_rd_reg;
                if (j_reg != tgt_len_reg)
                begin
                    rd_issue = 1'b1;
                    j_next   = LEN_W'(j_reg + 1'b1);
                end
                else if (i_reg == src_len_reg)
                begin
                    out_valid_next = 1'b1;
                    out_dist_next  = sat_dist(best);
                    out_ovf_next   = drop_reg;
                    src_len_next   = '0;
                    tgt_len_next   = '0;
                    drop_next      = 1'b0;
                end
                else
                begin
                    i_next       = LEN_W'(i_reg + 1'b1);
                    cur_row_next = up2_row_reg;
                    up_row_next  = cur_row_reg;
                    up2_row_next = up_row_reg;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            src_len_reg   <= '0;
            tgt_len_reg   <= '0;
            drop_reg      <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            src_len_reg   <= src_len_next;
            tgt_len_reg   <= tgt_len_next;
            drop_reg      <= drop_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_row_reg  <= cur_row_next;
        up_row_reg   <= up_row_next;
        up2_row_reg  <= up2_row_next;
        left_reg     <= left_next;
        diag_reg     <= diag_next;
        src_prev_reg <= src_prev_next;
        tc_prev_reg  <= tc_prev_next;
        out_dist_reg <= out_dist_next;
        out_ovf_reg  <= out_ovf_next;
    end

    always_ff @(posedge clk)
    begin
        if (src_we)
        begin
            src_mem[src_len_reg[IDX_W-1:0]] <= head.cmd.ch;
        end
        if (src_re)
        begin
            src_rd_reg <= src_mem[src_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tgt_we)
        begin
            tgt_mem[tgt_len_reg[IDX_W-1:0]] <= head.cmd.ch;
        end
        if (rd_issue)
        begin
            tgt_rd_reg <= tgt_mem[tgt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sc_we)
        begin
            score_mem[sc_waddr] <= best;
        end
        if (rd_issue)
        begin
            up_rd_reg  <= score_mem[up_addr];
            up2_rd_reg <= score_mem[up2_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_ovf_reg, out_dist_reg};

endmodule

// ===== hdl/edit_distance_with_transposition_core.sv =====
// ============================================================================
// edit_distance_with_transposition_core: string edit distance engine
// Append requests: one per cycle while the queue has room and the engine is
// idle; each is queued, then written to its character store. Compute request,
// engine idle: result registered directly when either string is empty, else
// one cell per cycle through the single score memory, with a setup state per row.
// rst_n is asynchronous: lengths, overflow flag, queue and result valid cleared.
// ============================================================================
module edit_distance_with_transposition_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [edc_pkg::CHAR_PORT_W-1:0] s_tdata,   // [15:0] char_code
    input  logic [edc_pkg::KIND_W-1:0]      s_tuser,   // [1:0] kind
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata    // [6:0] distance, [7] overflow
);
    import edc_pkg::*;

    // Queue head and pop travel between intake and engine. The intake keeps
    // taking requests (up to the queue depth) while the engine sweeps a
    // score table or holds a result that the sink has not taken yet.
    qhead_t head;
    logic   pop;

    // Intake: decodes kind, discards the unused kind, queues the rest.
    edc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .pop      (pop)
    );

    // Engine: character stores, score rows (three rolling rows in one
    // memory) and the result register. A compute request waits at the head
    // of the queue until the result register is free.
    edc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== hdl/edc_checker.sv =====
// ============================================================================
// edc_checker: port-level checks for the edit distance core
// Watches the result stream of the top level over time.
// ============================================================================
module edc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    import edc_pkg::*;

    // a held result keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // distance never exceeds the string capacity
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(m_tdata[DIST_W-1:0]) <= MAX_LEN))
        else $error("distance out of range");

    // one result per compute request: no second result right after a transfer
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |=> !m_tvalid)
        else $error("result repeated after transfer");

endmodule

bind edit_distance_with_transposition_core edc_checker u_edc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/tb_edit_distance_with_transposition_core.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_edit_distance_with_transposition_core: self-checking bench for the core
// Loads source and target strings over the request stream and issues compute
// requests. Each returned distance and overflow bit is checked against a
// behavioral edit distance model (with restricted transposition) kept here.
// Directed cases come first, then random string pairs under several idle and
// backpressure mixes.
// ============================================================================
module tb_edit_distance_with_transposition_core;

    import edc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;  // unused kind, dropped by the core
    localparam int STALL_LIMIT = 20000;               // budget for the longest compute, plus stalls

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } dist_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [CHAR_PORT_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [7:0]             m_tdata;

    // model state
    logic [CHAR_BITS-1:0] src_chars[$];
    logic [CHAR_BITS-1:0] tgt_chars[$];
    logic                 chars_dropped = 1'b0;
    dist_result_t         pending_distances[$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int fail_count = 0;
    int idle_cycles = 0;

    edit_distance_with_transposition_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [15:0] char_code
        .s_tuser  (s_tuser),   // [1:0] kind
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [6:0] distance, [7] overflow
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Model: full DP matrix. Transposition is tried only when both
    // 1-based indices exceed 2, exactly as the core is specified.
    // ------------------------------------------------------------------
    function automatic int unsigned osa_distance();
        int unsigned d[0:MAX_LEN][0:MAX_LEN];
        int unsigned best;
        int unsigned alt;
        int n;
        int m;
        n = src_chars.size();
        m = tgt_chars.size();
        if (n == 0)
        begin
            return m;
        end
        if (m == 0)
        begin
            return n;
        end
        for (int j = 0; j <= m; j++)
        begin
            d[0][j] = j;
        end
        for (int i = 1; i <= n; i++)
        begin
            d[i][0] = i;
            for (int j = 1; j <= m; j++)
            begin
                best = d[i-1][j-1] + ((src_chars[i-1] == tgt_chars[j-1]) ? 0 : 1);
                if (d[i][j-1] + 1 < best)
                begin
                    best = d[i][j-1] + 1;
                end
                if (d[i-1][j] + 1 < best)
                begin
                    best = d[i-1][j] + 1;
                end
                if (i > 2 && j > 2)
                begin
                    // crossing pair; each mismatching side costs one more
                    alt = d[i-2][j-2] + 1;
                    alt += (src_chars[i-2] != tgt_chars[j-1]) ? 1 : 0;
                    alt += (src_chars[i-1] != tgt_chars[j-2]) ? 1 : 0;
                    if (alt < best)
                    begin
                        best = alt;
                    end
                end
                d[i][j] = best;
            end
        end
        return d[n][m];
    endfunction

    // Applies one accepted request to the model state.
    function automatic void track_request(logic [KIND_W-1:0] kind,
                                          logic [CHAR_PORT_W-1:0] code);
        dist_result_t res;
        int unsigned dist_val;
        case (kind)
            KIND_SRC:
            begin
                if (src_chars.size() < MAX_LEN)
                begin
                    src_chars.push_back(code[CHAR_BITS-1:0]);
                end
                else
                begin
                    chars_dropped = 1'b1;
                end
            end
            KIND_TGT:
            begin
                if (tgt_chars.size() < MAX_LEN)
                begin
                    tgt_chars.push_back(code[CHAR_BITS-1:0]);
                end
                else
                begin
                    chars_dropped = 1'b1;
                end
            end
            KIND_RUN:
            begin
                dist_val = osa_distance();
                if (dist_val > DIST_MAX)
                begin
                    dist_val = DIST_MAX;
                end
                res.distance = dist_val[DIST_W-1:0];
                res.overflow = chars_dropped;
                pending_distances.push_back(res);
                src_chars.delete();
                tgt_chars.delete();
                chars_dropped = 1'b0;
            end
            default:
            begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request driver: optional idle gap, then hold the request until the
    // core takes it. Valid is left high so back-to-back requests stream.
    // ------------------------------------------------------------------
    task automatic send_req(input logic [KIND_W-1:0] kind, input logic [CHAR_PORT_W-1:0] code);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= CHAR_PORT_W'($urandom);
            s_tuser  <= KIND_W'($urandom);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= code;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        track_request(kind, code);
    endtask

    // Sender holds off until every outstanding distance has been returned.
    task automatic wait_results_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_distances.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Result sink and checker
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_distances.size() == 0)
            begin
                $error("unexpected result: distance=%0d overflow=%0b",
                       m_tdata[6:0], m_tdata[7]);
                fail_count++;
            end
            else
            begin
                if (m_tdata[6:0] !== pending_distances[0].distance)
                begin
                    $error("distance: expected %0d, got %0d",
                           pending_distances[0].distance, m_tdata[6:0]);
                    fail_count++;
                end
                if (m_tdata[7] !== pending_distances[0].overflow)
                begin
                    $error("overflow: expected %0b, got %0b",
                           pending_distances[0].overflow, m_tdata[7]);
                    fail_count++;
                end
                void'(pending_distances.pop_front());
            end
        end
    end

    // Watchdog: any accepted request or result restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty string on either side returns the other length.
    task automatic test_empty_strings();
        send_req(KIND_RUN, 16'h0000);
        send_req(KIND_SRC, 16'hFFFF);
        send_req(KIND_RUN, 16'hFFFF);
        send_req(KIND_TGT, 16'h0000);
        send_req(KIND_RUN, 16'h0000);
    endtask

    // Swap at the third position may use the transposition term; a swap of
    // the first two characters may not.
    task automatic test_transposition();
        send_req(KIND_SRC, 16'h0001);
        send_req(KIND_SRC, 16'h5555);
        send_req(KIND_SRC, 16'hAAAA);
        send_req(KIND_TGT, 16'h0001);
        send_req(KIND_TGT, 16'hAAAA);
        send_req(KIND_TGT, 16'h5555);
        send_req(KIND_RUN, 16'h0000);
        send_req(KIND_SRC, 16'h8000);
        send_req(KIND_SRC, 16'h7FFF);
        send_req(KIND_TGT, 16'h7FFF);
        send_req(KIND_TGT, 16'h8000);
        send_req(KIND_RUN, 16'hFFFF);
    endtask

    // Kind 3 must leave strings and results untouched.
    task automatic test_ignored_kind();
        send_req(KIND_NONE, 16'hFFFF);
        send_req(KIND_SRC, 16'h1234);
        send_req(KIND_NONE, 16'h0000);
        send_req(KIND_TGT, 16'h1234);
        send_req(KIND_RUN, 16'h0000);
    endtask

    // Both strings filled past capacity, then a compute that reports overflow and
    // an empty compute to see the overflow flag cleared.
    task automatic test_capacity();
        for (int k = 0; k < MAX_LEN + 2; k++)
        begin
            send_req(KIND_SRC, CHAR_PORT_W'($urandom));
        end
        for (int k = 0; k < MAX_LEN + 1; k++)
        begin
            send_req(KIND_TGT, CHAR_PORT_W'($urandom));
        end
        send_req(KIND_RUN, CHAR_PORT_W'($urandom));
        send_req(KIND_RUN, CHAR_PORT_W'($urandom));
        wait_results_drained();
    endtask

    // Picks a string length: mostly short, some medium, rarely near or past capacity.
    function automatic int pick_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 2)
        begin
            return $urandom_range(MAX_LEN + 4, MAX_LEN - 4);
        end
        if (pick < 10)
        begin
            return $urandom_range(20);
        end
        return $urandom_range(8);
    endfunction

    // One string pair with random content, appends interleaved, then compute.
    // Half the targets are edits of the source so matches and swaps show up.
    task automatic send_random_pair(output int n_sent);
        logic [CHAR_BITS-1:0] a[$];
        logic [CHAR_BITS-1:0] b[$];
        logic [CHAR_BITS-1:0] base;
        logic [CHAR_BITS-1:0] tmp;
        bit narrow;
        int la;
        int lb;
        int ia;
        int ib;
        int p;
        narrow = $urandom_range(1);
        base = CHAR_BITS'($urandom);
        la = pick_length();
        for (int k = 0; k < la; k++)
        begin
            a.push_back(narrow ? base ^ CHAR_BITS'($urandom_range(3)) : CHAR_BITS'($urandom));
        end
        if ($urandom_range(1))
        begin
            b = a;
            repeat ($urandom_range(3))
            begin
                p = (b.size() > 1) ? $urandom_range(b.size() - 2) : 0;
                case ($urandom_range(3))
                    0:
                    begin
                        if (b.size() > 1)
                        begin
                            tmp = b[p];
                            b[p] = b[p+1];
                            b[p+1] = tmp;
                        end
                    end
                    1:
                    begin
                        if (b.size() > 0)
                        begin
                            b[p] = base ^ CHAR_BITS'($urandom_range(3));
                        end
                    end
                    2:
                    begin
                        b.insert(p, base ^ CHAR_BITS'($urandom_range(3)));
                    end
                    default:
                    begin
                        if (b.size() > 0)
                        begin
                            b.delete(p);
                        end
                    end
                endcase
            end
        end
        else
        begin
            lb = pick_length();
            for (int k = 0; k < lb; k++)
            begin
                b.push_back(narrow ? base ^ CHAR_BITS'($urandom_range(3)) : CHAR_BITS'($urandom));
            end
        end
        ia = 0;
        ib = 0;
        while (ia < a.size() || ib < b.size())
        begin
            if ($urandom_range(19) == 0)
            begin
                send_req(KIND_NONE, CHAR_PORT_W'($urandom));
            end
            if (ib >= b.size() || (ia < a.size() && $urandom_range(1)))
            begin
                send_req(KIND_SRC, a[ia]);
                ia++;
            end
            else
            begin
                send_req(KIND_TGT, b[ib]);
                ib++;
            end
        end
        send_req(KIND_RUN, CHAR_PORT_W'($urandom));
        n_sent = a.size() + b.size() + 1;
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items);
        int sent;
        int n;
        sent = 0;
        src_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        while (sent < n_items)
        begin
            send_random_pair(n);
            sent += n;
        end
        wait_results_drained();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_strings();
        test_transposition();
        test_ignored_kind();
        wait_results_drained();
        test_capacity();

        test_random_traffic(0, 0, 375);
        test_random_traffic(76, 0, 375);
        test_random_traffic(0, 76, 375);
        test_random_traffic(25, 25, 375);

        // nothing left outstanding; give stray results a chance to show up
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending_distances.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== edit_distance_with_transposition_core.f =====
hdl/edc_pkg.sv
hdl/edc_front.sv
hdl/edc_back.sv
hdl/edit_distance_with_transposition_core.sv
hdl/edc_checker.sv
sim/tb_edit_distance_with_transposition_core.sv
